// ----- rtl/core/vtjs_pkg.sv -----
// vtjs_pkg: shared types, constants and arithmetic helpers of the joint stepper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package vtjs_pkg;

    localparam int IMAGE_WIDTH  = 640;
    localparam int IMAGE_HEIGHT = 480;
    localparam int CENTER_BAND  = 100;
    localparam int VERT_HIGH    = 320;
    localparam int VERT_LOW     = 260;

    localparam int CMD_W   = 3;
    localparam int XPIX_W  = 10;
    localparam int YPIX_W  = 9;
    localparam int STEP_W  = 11;
    localparam int LIMIT_W = 14;
    localparam int ANGLE_W = 15;
    localparam int OFF_W   = 16;
    localparam int TGT_W   = 16;
    localparam int WIDE_W  = 17;
    localparam int COORD_W = 14;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_BOX      = 3'd0,
        CMD_FEEDBACK = 3'd1,
        CMD_TICK     = 3'd2,
        CMD_HOME     = 3'd3,
        CMD_ZERO     = 3'd4
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_H_STEP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_H_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_V_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_V_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_BASE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_ELBOW = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_WRIST = 3'd6;

    localparam logic [STEP_W-1:0]         STEP_RST       = 11'd64;
    localparam logic [LIMIT_W-1:0]        LIMIT_RST      = 14'd5760;
    localparam logic signed [ANGLE_W-1:0] HOME_BASE_RST  = 15'sd0;
    localparam logic signed [ANGLE_W-1:0] HOME_ELBOW_RST = -15'sd4480;
    localparam logic signed [ANGLE_W-1:0] HOME_WRIST_RST = 15'sd896;

    typedef struct packed {
        logic [STEP_W-1:0]         h_step;
        logic [LIMIT_W-1:0]        h_limit;
        logic [STEP_W-1:0]         v_step;
        logic [LIMIT_W-1:0]        v_limit;
        logic signed [ANGLE_W-1:0] home_base;
        logic signed [ANGLE_W-1:0] home_elbow;
        logic signed [ANGLE_W-1:0] home_wrist;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic [XPIX_W-1:0]         box_left;
        logic [YPIX_W-1:0]         box_top;
        logic [XPIX_W-1:0]         box_right;
        logic [YPIX_W-1:0]         box_bottom;
        logic signed [ANGLE_W-1:0] measured_base;
        logic signed [ANGLE_W-1:0] measured_elbow;
        logic signed [ANGLE_W-1:0] measured_wrist;
    } item_t;

    typedef struct packed {
        logic signed [TGT_W-1:0] target_base;
        logic signed [TGT_W-1:0] target_elbow;
        logic signed [TGT_W-1:0] target_wrist;
    } result_t;

    typedef struct packed {
        logic signed [1:0]         h_dir;
        logic signed [1:0]         v_dir;
        logic signed [OFF_W-1:0]   h_off;
        logic signed [OFF_W-1:0]   v_off;
        logic signed [ANGLE_W-1:0] meas_base;
        logic signed [ANGLE_W-1:0] meas_elbow;
        logic signed [ANGLE_W-1:0] meas_wrist;
        logic signed [TGT_W-1:0]   tgt_base;
        logic signed [TGT_W-1:0]   tgt_elbow;
        logic signed [TGT_W-1:0]   tgt_wrist;
    } state_t;

    // offset +/- step, then saturate to +/- limit
    function automatic logic signed [OFF_W-1:0] step_sat(
        input logic signed [OFF_W-1:0] off,
        input logic signed [1:0]       dir,
        input logic [STEP_W-1:0]       step,
        input logic [LIMIT_W-1:0]      limit
    );
        logic signed [WIDE_W-1:0] v;
        logic signed [WIDE_W-1:0] lim;
        logic signed [WIDE_W-1:0] stp;
        stp = $signed({{(WIDE_W-STEP_W){1'b0}}, step});
        lim = $signed({{(WIDE_W-LIMIT_W){1'b0}}, limit});
        if (dir > 0)
        begin
            v = WIDE_W'(off) + stp;
        end
        else
        begin
            v = WIDE_W'(off) - stp;
        end
        if (v < -lim)
        begin
            v = -lim;
        end
        if (v > lim)
        begin
            v = lim;
        end
        return v[OFF_W-1:0];
    endfunction

    // keep the target within two steps of the measured angle, upper bound first
    function automatic logic signed [TGT_W-1:0] near_clamp(
        input logic signed [WIDE_W-1:0]  t,
        input logic signed [ANGLE_W-1:0] meas,
        input logic [STEP_W-1:0]         step
    );
        logic signed [WIDE_W-1:0] span;
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        logic signed [WIDE_W-1:0] v;
        span = $signed({{(WIDE_W-STEP_W-1){1'b0}}, step, 1'b0});
        hi = WIDE_W'(meas) + span;
        lo = WIDE_W'(meas) - span;
        v = t;
        if (v > hi)
        begin
            v = hi;
        end
        if (v < lo)
        begin
            v = lo;
        end
        return v[TGT_W-1:0];
    endfunction

endpackage

// ----- rtl/core/vtjs_step.sv -----
// vtjs_step: one item's work, next state and optional result from current state.
// Depends on vtjs_pkg.
`timescale 1ns / 1ps

module vtjs_step (
    input  vtjs_pkg::cfg_t    cfg,
    input  vtjs_pkg::state_t  st,
    input  vtjs_pkg::item_t   item,
    output vtjs_pkg::state_t  st_next,
    output logic              has_result,
    output vtjs_pkg::result_t res
);
    import vtjs_pkg::*;

    logic [XPIX_W:0]            x_sum;
    logic [COORD_W-1:0]         x_sum_ext;
    logic [YPIX_W-1:0]          y_min;
    logic signed [COORD_W-1:0]  h_val;
    logic signed [1:0]          h_dir_new;
    logic signed [1:0]          v_dir_new;
    logic signed [OFF_W-1:0]    h_off_new;
    logic signed [OFF_W-1:0]    v_off_new;

    always_comb
    begin
        x_sum     = {1'b0, item.box_left} + {1'b0, item.box_right};
        x_sum_ext = COORD_W'(x_sum);
        y_min     = (item.box_top < item.box_bottom) ? item.box_top : item.box_bottom;
        h_val     = $signed(COORD_W'(IMAGE_HEIGHT)) - $signed(COORD_W'(y_min));

        if (x_sum_ext > COORD_W'(IMAGE_WIDTH - CENTER_BAND) &&
            x_sum_ext < COORD_W'(IMAGE_WIDTH + CENTER_BAND))
        begin
            h_dir_new = 2'sd0;
        end
        else if (x_sum_ext < COORD_W'(IMAGE_WIDTH))
        begin
            h_dir_new = -2'sd1;
        end
        else
        begin
            h_dir_new = 2'sd1;
        end

        if (h_val > $signed(COORD_W'(VERT_HIGH)))
        begin
            v_dir_new = 2'sd1;
        end
        else if (h_val < $signed(COORD_W'(VERT_LOW)))
        begin
            v_dir_new = -2'sd1;
        end
        else
        begin
            v_dir_new = 2'sd0;
        end

        h_off_new = step_sat(st.h_off, st.h_dir, cfg.h_step, cfg.h_limit);
        v_off_new = step_sat(st.v_off, st.v_dir, cfg.v_step, cfg.v_limit);
    end

    always_comb
    begin
        st_next    = st;
        has_result = 1'b0;
        case (item.cmd)
            CMD_BOX:
            begin
                st_next.h_dir = h_dir_new;
                st_next.v_dir = v_dir_new;
            end
            CMD_FEEDBACK:
            begin
                st_next.meas_base  = item.measured_base;
                st_next.meas_elbow = item.measured_elbow;
                st_next.meas_wrist = item.measured_wrist;
            end
            CMD_TICK:
            begin
                if (st.h_dir != 2'sd0)
                begin
                    st_next.h_off    = h_off_new;
                    st_next.tgt_base = near_clamp(WIDE_W'(cfg.home_base) + WIDE_W'(h_off_new),
                                                  st.meas_base, cfg.h_step);
                end
                if (st.v_dir != 2'sd0)
                begin
                    st_next.v_off     = v_off_new;
                    st_next.tgt_elbow = near_clamp(WIDE_W'(cfg.home_elbow) - WIDE_W'(v_off_new),
                                                   st.meas_elbow, cfg.v_step);
                    st_next.tgt_wrist = near_clamp(WIDE_W'(cfg.home_wrist) + WIDE_W'(v_off_new),
                                                   st.meas_wrist, cfg.v_step);
                end
                has_result = (st.h_dir != 2'sd0) || (st.v_dir != 2'sd0);
            end
            CMD_HOME:
            begin
                st_next.tgt_base  = TGT_W'(cfg.home_base);
                st_next.tgt_elbow = TGT_W'(cfg.home_elbow);
                st_next.tgt_wrist = TGT_W'(cfg.home_wrist);
                has_result        = 1'b1;
            end
            CMD_ZERO:
            begin
                st_next.tgt_base  = '0;
                st_next.tgt_elbow = '0;
                st_next.tgt_wrist = '0;
                has_result        = 1'b1;
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase

        res.target_base  = st_next.tgt_base;
        res.target_elbow = st_next.tgt_elbow;
        res.target_wrist = st_next.tgt_wrist;
    end

endmodule

// ----- rtl/core/visual_tracking_joint_stepper.sv -----
// visual_tracking_joint_stepper: top level, input register, state, result register.
// Depends on vtjs_pkg and vtjs_step.
//
//   channel  | dir | handshake               | content
//   s_axis   | in  | s_axis_tvalid/tready    | tuser cmd, tdata box and measured angles
//   m_axis   | out | m_axis_tvalid/tready    | tdata target base, elbow, wrist
//   cfg      | in  | cfg_valid/cfg_ready     | cfg_index register, cfg_data value
//
// One item per cycle sustained while no result is stalled; an item waits in the input register,
// where the step logic updates the state, and a result lands in the output register.
// Result valid is registered: it rises when the item leaves the input register and its result is written.
// Reset restores register defaults and clears all state; no clearing pass.
// A stalled result holds the input register only for items that give a result.
`timescale 1ns / 1ps

module visual_tracking_joint_stepper (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: box_left[9:0], box_top[18:10], box_right[28:19], box_bottom[37:29],
    //        measured_base[52:38], measured_elbow[67:53], measured_wrist[82:68], zero pad
    input  logic [vtjs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: cmd[2:0]
    input  logic [vtjs_pkg::CMD_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: target_base[15:0], target_elbow[31:16], target_wrist[47:32]
    output logic [vtjs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [vtjs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vtjs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import vtjs_pkg::*;

    cfg_t    cfg_reg;
    state_t  st_reg;
    state_t  st_next;
    item_t   item_reg;
    item_t   item_in;
    logic    item_valid_reg;
    result_t res_next;
    result_t res_reg;
    logic    out_valid_reg;
    logic    has_result;
    logic    out_free;
    logic    stage_go;

    assign item_in.cmd            = s_axis_tuser;
    assign item_in.box_left       = s_axis_tdata[9:0];
    assign item_in.box_top        = s_axis_tdata[18:10];
    assign item_in.box_right      = s_axis_tdata[28:19];
    assign item_in.box_bottom     = s_axis_tdata[37:29];
    assign item_in.measured_base  = s_axis_tdata[52:38];
    assign item_in.measured_elbow = s_axis_tdata[67:53];
    assign item_in.measured_wrist = s_axis_tdata[82:68];

    vtjs_step u_step (
        .cfg        (cfg_reg),
        .st         (st_reg),
        .item       (item_reg),
        .st_next    (st_next),
        .has_result (has_result),
        .res        (res_next)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign stage_go      = item_valid_reg && (!has_result || out_free);
    assign s_axis_tready = !item_valid_reg || stage_go;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {res_reg.target_wrist, res_reg.target_elbow, res_reg.target_base};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.h_step     <= STEP_RST;
            cfg_reg.h_limit    <= LIMIT_RST;
            cfg_reg.v_step     <= STEP_RST;
            cfg_reg.v_limit    <= LIMIT_RST;
            cfg_reg.home_base  <= HOME_BASE_RST;
            cfg_reg.home_elbow <= HOME_ELBOW_RST;
            cfg_reg.home_wrist <= HOME_WRIST_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_H_STEP:     cfg_reg.h_step     <= cfg_data[STEP_W-1:0];
                REG_H_LIMIT:    cfg_reg.h_limit    <= cfg_data[LIMIT_W-1:0];
                REG_V_STEP:     cfg_reg.v_step     <= cfg_data[STEP_W-1:0];
                REG_V_LIMIT:    cfg_reg.v_limit    <= cfg_data[LIMIT_W-1:0];
                REG_HOME_BASE:  cfg_reg.home_base  <= $signed(cfg_data[ANGLE_W-1:0]);
                REG_HOME_ELBOW: cfg_reg.home_elbow <= $signed(cfg_data[ANGLE_W-1:0]);
                REG_HOME_WRIST: cfg_reg.home_wrist <= $signed(cfg_data[ANGLE_W-1:0]);
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= '0;
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (stage_go)
            begin
                st_reg <= st_next;
            end
            if (s_axis_tready)
            begin
                item_valid_reg <= s_axis_tvalid;
            end
            if (stage_go && has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg <= item_in;
        end
        if (stage_go && has_result)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ----- rtl/core/vtjs_checker.sv -----
// vtjs_checker: port-level assertions for the joint stepper, bound to the top level.
// Depends on vtjs_pkg and visual_tracking_joint_stepper.
`timescale 1ns / 1ps

module vtjs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [vtjs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic [vtjs_pkg::CMD_W-1:0]      s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [vtjs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [vtjs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [vtjs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import vtjs_pkg::*;

    logic zero_acc;
    assign zero_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_ZERO);

    // held result keeps its data
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a new result needs an item accepted before it
    a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a preceding item");

    // empty output never blocks the input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // zero command reaches the output as all-zero targets
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        (zero_acc && !m_axis_tvalid) ##1 m_axis_tready |=>
            m_axis_tvalid && (m_axis_tdata == '0))
        else $error("zero command gave nonzero targets");

endmodule

bind visual_tracking_joint_stepper vtjs_checker u_vtjs_checker (.*);

// ----- tb/sv/tb_visual_tracking_joint_stepper.sv -----
`timescale 1ns / 1ps
// tb_visual_tracking_joint_stepper: self-checking bench for the visual tracking joint stepper.
// Runs directed corner items, then random tracking sequences under several register sets.
// Depends on vtjs_pkg and visual_tracking_joint_stepper.

module tb_visual_tracking_joint_stepper;
    import vtjs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam logic [CMD_W-1:0]     CMD_TOP   = 3'd7;
    localparam int ITEMS_PER_PHASE = 250;

    // predicts the joint targets and holds the ones still owed by the block
    class target_board;
        cfg_t    regs;
        int      h_dir;
        int      v_dir;
        int      h_off;
        int      v_off;
        int      meas[3];
        int      tgt[3];
        result_t expected_targets[$];
        int      mismatches;

        function new();
            regs.h_step     = 64;
            regs.h_limit    = 5760;
            regs.v_step     = 64;
            regs.v_limit    = 5760;
            regs.home_base  = 0;
            regs.home_elbow = -4480;
            regs.home_wrist = 896;
            h_dir = 0;
            v_dir = 0;
            h_off = 0;
            v_off = 0;
            meas = '{0, 0, 0};
            tgt = '{0, 0, 0};
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                REG_H_STEP:     regs.h_step = v[STEP_W-1:0];
                REG_H_LIMIT:    regs.h_limit = v[LIMIT_W-1:0];
                REG_V_STEP:     regs.v_step = v[STEP_W-1:0];
                REG_V_LIMIT:    regs.v_limit = v[LIMIT_W-1:0];
                REG_HOME_BASE:  regs.home_base = v[ANGLE_W-1:0];
                REG_HOME_ELBOW: regs.home_elbow = v[ANGLE_W-1:0];
                REG_HOME_WRIST: regs.home_wrist = v[ANGLE_W-1:0];
                default: ;
            endcase
        endfunction

        function int bound(int v, int lim);
            if (v < -lim)
                v = -lim;
            if (v > lim)
                v = lim;
            return v;
        endfunction

        // upper bound checked first
        function int near(int t, int m, int s);
            if (t > m + 2 * s)
                t = m + 2 * s;
            if (t < m - 2 * s)
                t = m - 2 * s;
            return t;
        endfunction

        function void post_targets();
            result_t r;
            r.target_base  = TGT_W'(tgt[0]);
            r.target_elbow = TGT_W'(tgt[1]);
            r.target_wrist = TGT_W'(tgt[2]);
            expected_targets.push_back(r);
        endfunction

        function void take_item(item_t it);
            int sx;
            int y_low;
            int h;
            case (it.cmd)
                CMD_BOX:
                begin
                    sx = int'(it.box_left) + int'(it.box_right);
                    y_low = (it.box_top < it.box_bottom) ? int'(it.box_top) : int'(it.box_bottom);
                    h = IMAGE_HEIGHT - y_low;
                    if (sx > IMAGE_WIDTH - CENTER_BAND && sx < IMAGE_WIDTH + CENTER_BAND)
                        h_dir = 0;
                    else if (sx < IMAGE_WIDTH)
                        h_dir = -1;
                    else
                        h_dir = 1;
                    if (h > VERT_HIGH)
                        v_dir = 1;
                    else if (h < VERT_LOW)
                        v_dir = -1;
                    else
                        v_dir = 0;
                end
                CMD_FEEDBACK:
                begin
                    meas[0] = int'(it.measured_base);
                    meas[1] = int'(it.measured_elbow);
                    meas[2] = int'(it.measured_wrist);
                end
                CMD_TICK:
                begin
                    if (h_dir == 0 && v_dir == 0)
                        return;
                    if (h_dir != 0)
                    begin
                        h_off = bound(h_off + h_dir * int'(regs.h_step), int'(regs.h_limit));
                        tgt[0] = near(int'(regs.home_base) + h_off, meas[0], int'(regs.h_step));
                    end
                    if (v_dir != 0)
                    begin
                        v_off = bound(v_off + v_dir * int'(regs.v_step), int'(regs.v_limit));
                        tgt[1] = near(int'(regs.home_elbow) - v_off, meas[1], int'(regs.v_step));
                        tgt[2] = near(int'(regs.home_wrist) + v_off, meas[2], int'(regs.v_step));
                    end
                    post_targets();
                end
                CMD_HOME:
                begin
                    tgt[0] = int'(regs.home_base);
                    tgt[1] = int'(regs.home_elbow);
                    tgt[2] = int'(regs.home_wrist);
                    post_targets();
                end
                CMD_ZERO:
                begin
                    tgt = '{0, 0, 0};
                    post_targets();
                end
                default: ;
            endcase
        endfunction

        function void check_targets(logic [OUT_DATA_W-1:0] d);
            logic signed [TGT_W-1:0] got_b;
            logic signed [TGT_W-1:0] got_e;
            logic signed [TGT_W-1:0] got_w;
            result_t want;
            got_b = d[15:0];
            got_e = d[31:16];
            got_w = d[47:32];
            if (expected_targets.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected targets %0d %0d %0d", $time, got_b, got_e, got_w);
                return;
            end
            want = expected_targets.pop_front();
            if (got_b !== want.target_base || got_e !== want.target_elbow ||
                got_w !== want.target_wrist)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: targets expected %0d %0d %0d, got %0d %0d %0d", $time,
                             want.target_base, want.target_elbow, want.target_wrist,
                             got_b, got_e, got_w);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]      s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    target_board board = new();
    bit          idle_on = 1'b1;
    int          tracked = 0;

    visual_tracking_joint_stepper dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_targets(m_axis_tdata);
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic item_t random_fields();
        item_t it;
        it.cmd            = 3'($urandom);
        it.box_left       = 10'($urandom);
        it.box_top        = 9'($urandom);
        it.box_right      = 10'($urandom);
        it.box_bottom     = 9'($urandom);
        it.measured_base  = 15'($urandom);
        it.measured_elbow = 15'($urandom);
        it.measured_wrist = 15'($urandom);
        return it;
    endfunction

    function automatic item_t cmd_item(logic [CMD_W-1:0] c);
        item_t it;
        it = random_fields();
        it.cmd = c;
        return it;
    endfunction

    // boxes biased toward the edges of the horizontal and vertical bands
    function automatic item_t box_item();
        item_t it;
        int sx;
        int x1;
        int y_min;
        int y_other;
        it = cmd_item(CMD_BOX);
        case ($urandom_range(0, 2))
            0:
            begin
                it.box_left  = 10'($urandom_range(0, 639));
                it.box_right = 10'($urandom_range(0, 639));
            end
            1:
            begin
                sx = ($urandom_range(0, 1) ? IMAGE_WIDTH - CENTER_BAND
                                           : IMAGE_WIDTH + CENTER_BAND - 1)
                     + int'($urandom_range(0, 3)) - 1;
                x1 = $urandom_range(sx > 639 ? sx - 639 : 0, sx < 639 ? sx : 639);
                it.box_left  = 10'(x1);
                it.box_right = 10'(sx - x1);
            end
            default: ;
        endcase
        case ($urandom_range(0, 2))
            0: y_min = ($urandom_range(0, 1) ? IMAGE_HEIGHT - VERT_HIGH - 1
                                             : IMAGE_HEIGHT - VERT_LOW)
                       + int'($urandom_range(0, 3)) - 1;
            1: y_min = $urandom_range(0, 479);
            default: y_min = -1;
        endcase
        if (y_min >= 0)
        begin
            y_other = $urandom_range(y_min, 479);
            if ($urandom_range(0, 1))
            begin
                it.box_top    = 9'(y_min);
                it.box_bottom = 9'(y_other);
            end
            else
            begin
                it.box_top    = 9'(y_other);
                it.box_bottom = 9'(y_min);
            end
        end
        return it;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] pick_angle(int center);
        int v;
        case ($urandom_range(0, 3))
            0: v = int'($signed(15'($urandom)));
            1: v = int'($urandom_range(0, 23040)) - 11520;
            default: v = center + int'($urandom_range(0, 512)) - 256;
        endcase
        if (v > 16383)
            v = 16383;
        if (v < -16384)
            v = -16384;
        return v[ANGLE_W-1:0];
    endfunction

    function automatic item_t angle_item();
        item_t it;
        it = cmd_item(CMD_FEEDBACK);
        it.measured_base  = pick_angle(int'(board.regs.home_base) + board.h_off);
        it.measured_elbow = pick_angle(int'(board.regs.home_elbow) - board.v_off);
        it.measured_wrist = pick_angle(int'(board.regs.home_wrist) + board.v_off);
        return it;
    endfunction

    task automatic send_item(input item_t it);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.cmd;
        // fields from the lowest bit up, zero pad on top
        s_axis_tdata  <= {5'b0, it.measured_wrist, it.measured_elbow, it.measured_base,
                          it.box_bottom, it.box_right, it.box_top, it.box_left};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        board.take_item(it);
        if (it.cmd <= CMD_ZERO)
            tracked++;
    endtask

    task automatic send_box(input int x1, input int y1, input int x2, input int y2);
        item_t it;
        it = cmd_item(CMD_BOX);
        it.box_left   = 10'(x1);
        it.box_top    = 9'(y1);
        it.box_right  = 10'(x2);
        it.box_bottom = 9'(y2);
        send_item(it);
    endtask

    task automatic send_angles(input int b, input int e, input int w);
        item_t it;
        it = cmd_item(CMD_FEEDBACK);
        it.measured_base  = 15'(b);
        it.measured_elbow = 15'(e);
        it.measured_wrist = 15'(w);
        send_item(it);
    endtask

    // holds the sender until every owed result is out, then lets the pipe empty
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (board.expected_targets.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.write_reg(idx, CFG_DATA_W'(value));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_pose(input int hs, input int hl, input int vs, input int vl,
                            input int hb, input int he, input int hw);
        wait_quiet();
        write_reg(REG_H_STEP, hs);
        write_reg(REG_H_LIMIT, hl);
        write_reg(REG_V_STEP, vs);
        write_reg(REG_V_LIMIT, vl);
        write_reg(REG_HOME_BASE, hb);
        write_reg(REG_HOME_ELBOW, he);
        write_reg(REG_HOME_WRIST, hw);
    endtask

    task automatic run_corners();
        int c;
        send_item(cmd_item(CMD_TICK));
        for (c = CMD_ZERO + 1; c <= CMD_TOP; c++)
            send_item(cmd_item(3'(c)));
        send_item(cmd_item(CMD_HOME));
        send_item(cmd_item(CMD_ZERO));
        send_angles(-16384, 16383, -11520);
        send_box(0, 160, 540, 479);
        send_item(cmd_item(CMD_TICK));
        send_box(300, 479, 241, 159);
        send_item(cmd_item(CMD_TICK));
        send_box(639, 479, 100, 220);
        send_item(cmd_item(CMD_TICK));
        send_box(639, 221, 101, 300);
        send_item(cmd_item(CMD_TICK));
        send_angles(0, 0, 0);
        send_box(1023, 511, 1023, 511);
        send_item(cmd_item(CMD_TICK));
        send_item(cmd_item(CMD_TICK));
        send_box(0, 0, 0, 0);
        send_item(cmd_item(CMD_TICK));
        send_angles(11520, -11520, 16383);
        send_item(cmd_item(CMD_TICK));
        send_item(cmd_item(CMD_HOME));
        send_item(cmd_item(CMD_ZERO));
    endtask

    // mostly feedback, box and a run of ticks; the rest is arbitrary items
    task automatic run_mix(input int n, input bit calm);
        int goal;
        goal = tracked + n;
        while (tracked < goal)
        begin
            idle_on = !calm && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 39) == 0)
                wait_quiet();
            if ($urandom_range(0, 9) < 7)
            begin
                if ($urandom_range(0, 1))
                    send_item(angle_item());
                send_item(box_item());
                repeat ($urandom_range(1, 8)) send_item(cmd_item(CMD_TICK));
                if ($urandom_range(0, 7) == 0)
                    send_item(cmd_item($urandom_range(0, 1) ? CMD_HOME : CMD_ZERO));
            end
            else
            begin
                repeat ($urandom_range(1, 4)) send_item(cmd_item(3'($urandom)));
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_corners();
        wait_quiet();
        write_reg(REG_SPARE, $urandom);
        run_mix(ITEMS_PER_PHASE, 1'b0);
        set_pose(1280, 11520, 1280, 11520, 11520, -11520, 11520);
        run_mix(ITEMS_PER_PHASE, 1'b0);
        set_pose(0, 0, 0, 0, -11520, 11520, -11520);
        run_mix(ITEMS_PER_PHASE, 1'b0);
        set_pose(2047, 16383, 2047, 16383, -16384, 16383, -16384);
        run_mix(ITEMS_PER_PHASE, 1'b0);
        set_pose($urandom_range(1, 40), $urandom_range(0, 400), $urandom_range(1, 40),
                 $urandom_range(0, 400), int'($urandom_range(0, 23040)) - 11520,
                 int'($urandom_range(0, 23040)) - 11520, int'($urandom_range(0, 23040)) - 11520);
        run_mix(ITEMS_PER_PHASE, 1'b0);
        set_pose($urandom_range(0, 1280), $urandom_range(0, 11520), $urandom_range(0, 1280),
                 $urandom_range(0, 11520), int'($urandom_range(0, 23040)) - 11520,
                 int'($urandom_range(0, 23040)) - 11520, int'($urandom_range(0, 23040)) - 11520);
        run_mix(ITEMS_PER_PHASE, 1'b0);
        set_pose(64, 5760, 64, 5760, 0, -4480, 896);
        run_mix(ITEMS_PER_PHASE, 1'b1);
        wait_quiet();
        if (board.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
